### src/dsbl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the domain suffix blocklist matcher.
// Depends on nothing; imported by the lane and top-level modules.
package dsbl_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE    = 1'b0,
      ST_COMPARE = 1'b1
   } state_type;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // Control that the top level broadcasts to every lane
   typedef struct packed {
      logic       wr_last;
      logic [7:0] wr_char;
      logic       clear;
      logic       cmp_en;
      logic       cmp_last;
      logic [7:0] cmp_char;
   } lane_ctrl_type;

endpackage

### src/dsbl_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module dsbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/dsbl_lane.sv
`timescale 1ns / 1ps
// One blocklist entry: byte memory, length, valid and running match flag.
// Depends on dsbl_pkg and dsbl_ram.
module dsbl_lane #(
   parameter int MAX_LEN = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dsbl_pkg::lane_ctrl_type      ctrl,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_LEN)-1:0]   wr_addr,
   input  logic [$clog2(MAX_LEN+1)-1:0] wr_len,
   input  logic [$clog2(MAX_LEN)-1:0]   rd_addr,
   input  logic [$clog2(MAX_LEN+1)-1:0] query_pos,
   output logic                         hit
);
   import dsbl_pkg::*;

   localparam int LW = $clog2(MAX_LEN + 1);

   logic [LW-1:0] len_ff, len_in;
   logic          valid_ff, valid_in;
   logic          alive_ff, alive_in;
   logic [7:0]    rd_byte;
   logic          active, below, at_end, mism, dot_hit, end_hit;

   dsbl_ram #(
      .WIDTH(8),
      .DEPTH(MAX_LEN)
   ) u_bytes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(ctrl.wr_char),
      .rd_addr(rd_addr),
      .rd_data(rd_byte)
   );

   always_comb begin
      active  = valid_ff & alive_ff;
      below   = query_pos < len_ff;
      at_end  = query_pos == len_ff;
      mism    = rd_byte != ctrl.cmp_char;
      dot_hit = active & at_end & (ctrl.cmp_char == DOT_CHAR);
      // both names end in the implicit dot
      end_hit = active & below & ~mism &
                ({1'b0, len_ff} == ({1'b0, query_pos} + {{LW{1'b0}}, 1'b1}));
      hit     = dot_hit | (ctrl.cmp_last & end_hit);

      len_in   = len_ff;
      valid_in = valid_ff;
      alive_in = alive_ff;
      if (ctrl.clear) begin
         len_in   = '0;
         valid_in = 1'b0;
         alive_in = 1'b1;
      end else begin
         if (wr_en) begin
            valid_in = ctrl.wr_last;
            if (ctrl.wr_last) begin
               len_in = wr_len;
            end
         end
         if (ctrl.cmp_en) begin
            if (ctrl.cmp_last) begin
               alive_in = 1'b1;
            end else if (active & ((below & mism) | at_end)) begin
               alive_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         valid_ff <= 1'b0;
         alive_ff <= 1'b1;
      end else begin
         len_ff   <= len_in;
         valid_ff <= valid_in;
         alive_ff <= alive_in;
      end
   end

endmodule

### src/domain_suffix_blocklist_match.sv
`timescale 1ns / 1ps
// Top level of the domain suffix blocklist matcher: control, query state, result register.
// Depends on dsbl_pkg, dsbl_lane and dsbl_ram.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   req     | req_valid/ready, opcode, entry_index, position,| in
//           | char_byte, last                                |
//   rsp     | rsp_valid/ready, forbidden                     | out
//
// Load, clear and unused-opcode items are handled in the idle state. A query byte
// first reads the position's row from every lane memory, then compares all lanes
// in parallel in the compare state; no new item is taken until it returns to idle.
// The last query byte waits in the compare state while the result register still
// holds an untaken result. Reset clears lengths, valid flags, match flags and query
// state and holds req_ready low; entry bytes are undefined until loaded.
module domain_suffix_blocklist_match #(
   parameter int ENTRIES = 64,
   parameter int MAX_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [5:0] req_entry_index,
   input  logic [7:0] req_position,
   input  logic [7:0] req_char_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_forbidden
);
   import dsbl_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);

   state_type     state_ff, state_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic          hit_seen_ff, hit_seen_in;
   logic [7:0]    ch_ff, ch_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          forbidden_ff, forbidden_in;

   lane_ctrl_type      ctrl;
   logic               accept, is_load, go, any_hit;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [LW-1:0]      wr_len;
   logic [ENTRIES-1:0] lane_wr, lane_hit;
   op_type             op;

   assign op      = op_type'(req_opcode);
   assign accept  = req_valid & req_ready;
   assign is_load = accept & (op == OP_LOAD);
   assign any_hit = |lane_hit;

   // Saturate the load position to the last byte of a row
   always_comb begin
      if (int'(req_position) >= MAX_LEN) begin
         wr_addr = AW'(MAX_LEN - 1);
      end else begin
         wr_addr = AW'(req_position);
      end
      wr_len = LW'({1'b0, wr_addr} + {{AW{1'b0}}, 1'b1});
      // Past the row end no byte is compared; any address will do
      if (pos_ff < LW'(MAX_LEN)) begin
         rd_addr = AW'(pos_ff);
      end else begin
         rd_addr = '0;
      end
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_lane
      assign lane_wr[i] = is_load & (int'(req_entry_index) == i);

      dsbl_lane #(
         .MAX_LEN(MAX_LEN)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_en    (lane_wr[i]),
         .wr_addr  (wr_addr),
         .wr_len   (wr_len),
         .rd_addr  (rd_addr),
         .query_pos(pos_ff),
         .hit      (lane_hit[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      hit_seen_in  = hit_seen_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      forbidden_in = forbidden_ff;
      // take no item while reset is applied
      req_ready    = (state_ff == ST_IDLE) & ~reset;
      go           = 1'b0;

      ctrl.wr_last  = req_last;
      ctrl.wr_char  = req_char_byte;
      ctrl.clear    = 1'b0;
      ctrl.cmp_en   = 1'b0;
      ctrl.cmp_last = last_ff;
      ctrl.cmp_char = ch_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_QUERY: begin
                     // memory row read for pos_ff is issued at this edge
                     ch_in    = req_char_byte;
                     last_in  = req_last;
                     state_in = ST_COMPARE;
                  end
                  OP_CLEAR: begin
                     ctrl.clear  = 1'b1;
                     pos_in      = '0;
                     hit_seen_in = 1'b0;
                  end
                  default: begin
                     // loads go straight to the lanes; unused opcode is dropped
                  end
               endcase
            end
         end
         ST_COMPARE: begin
            // hold the final byte until the result register is free
            go          = ~last_ff | ~rsp_valid_ff | rsp_ready;
            ctrl.cmp_en = go;
            if (go) begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
                  forbidden_in = hit_seen_ff | any_hit;
                  pos_in       = '0;
                  hit_seen_in  = 1'b0;
               end else begin
                  hit_seen_in = hit_seen_ff | any_hit;
                  if (pos_ff < LW'(MAX_LEN)) begin
                     pos_in = pos_ff + {{(LW-1){1'b0}}, 1'b1};
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         hit_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         hit_seen_ff  <= hit_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      last_ff      <= last_in;
      forbidden_ff <= forbidden_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_forbidden = forbidden_ff;

   // A new result appears only after the compare of a query's last byte
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMPARE && last_ff))
      else $error("result raised without a final query compare");

   // Query position never runs past the saturation point
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LW'(MAX_LEN))
      else $error("query position beyond maximum length");

   // A clear abandons the query in progress
   a_clear_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_CLEAR) |=> (pos_ff == '0 && !hit_seen_ff))
      else $error("query state not reset by clear");

   // A stalled final byte leaves the pending result untouched
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(forbidden_ff)))
      else $error("pending result overwritten");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for domain_suffix_blocklist_match: directed and random loads,
// queries and clears, with a bit-exact predictor of the table. Depends on dsbl_pkg.
module tb;
   import dsbl_pkg::*;

   localparam int ENTRIES       = 64;
   // A short row keeps full-length names cheap and puts many load positions
   // past the row end, where they saturate.
   localparam int MAX_LEN       = 32;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int HOLD_CYCLES   = 160;
   localparam int DRAIN_WAIT    = 16;
   localparam int ITEM_TARGET   = 450;
   localparam int VERDICT_DEPTH = 1024;

   // ---------------------------------------------------------------------
   // Clock, reset and the ports of the block
   // ---------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = OP_NONE;
   logic [5:0] req_entry_index = '0;
   logic [7:0] req_position = '0;
   logic [7:0] req_char_byte = '0;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_forbidden;

   always #2 clock = ~clock;

   domain_suffix_blocklist_match #(
      .ENTRIES(ENTRIES),
      .MAX_LEN(MAX_LEN)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_entry_index(req_entry_index),
      .req_position   (req_position),
      .req_char_byte  (req_char_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_forbidden  (rsp_forbidden)
   );

   // ---------------------------------------------------------------------
   // Predictor state: a mirror of the blocklist table and of the query in
   // progress. Liveness is kept inverted (row_dead) so that zero is reset.
   // ---------------------------------------------------------------------
   logic [7:0] row_byte    [ENTRIES][MAX_LEN];
   bit         row_written [ENTRIES][MAX_LEN];
   bit   [8:0] row_len     [ENTRIES];
   bit         row_valid   [ENTRIES];
   bit         row_dead    [ENTRIES];
   bit   [8:0] match_pos;
   bit         match_hit;

   // Expected verdicts in order, as a ring with running write and read counts
   bit         verdict_buf [VERDICT_DEPTH];
   int         verdict_wr = 0;
   int         verdict_rd = 0;

   // Name under construction, in presentation order (rightmost character first)
   logic [7:0] name_buf [512];
   int         name_len;

   int cycle_count = 0;
   int items_sent = 0;
   int verdicts_checked = 0;
   int verdicts_blocked = 0;
   int fail_count = 0;

   // Sender idling and receiver hold-off control
   bit steady = 1'b0;
   int burst_left = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void restart_match();
      for (int i = 0; i < ENTRIES; i++) row_dead[i] = 1'b0;
      match_pos = '0;
      match_hit = 1'b0;
   endfunction

   // Advance the table mirror by one accepted item; queue a verdict on a
   // query's last byte.
   task automatic apply_to_blocklist(op_type op, logic [5:0] idx, logic [7:0] pos,
                                     logic [7:0] ch, logic last);
      bit [8:0] p;
      bit       hit;
      int       sp;
      case (op)
         OP_LOAD: begin
            // positions past the row end land on its last byte
            sp = (int'(pos) >= MAX_LEN) ? MAX_LEN - 1 : int'(pos);
            row_byte[idx][sp] = ch;
            row_written[idx][sp] = 1'b1;
            if (last) begin
               row_len[idx] = 9'(sp + 1);
               row_valid[idx] = 1'b1;
            end else begin
               row_valid[idx] = 1'b0;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) begin
               row_len[i] = '0;
               row_valid[i] = 1'b0;
            end
            restart_match();
         end
         OP_QUERY: begin
            p = match_pos;
            hit = match_hit;
            for (int i = 0; i < ENTRIES; i++) begin
               if (row_valid[i] && !row_dead[i]) begin
                  if (p < row_len[i]) begin
                     if (row_byte[i][p] != ch) row_dead[i] = 1'b1;
                  end else if (p == row_len[i]) begin
                     // label boundary right after a full entry match
                     if (ch == DOT_CHAR) hit = 1'b1;
                     row_dead[i] = 1'b1;
                  end
               end
            end
            if (last) begin
               // implicit trailing dot: equal names also block
               if (p < MAX_LEN) begin
                  for (int i = 0; i < ENTRIES; i++)
                     if (row_valid[i] && !row_dead[i] && row_len[i] == p + 9'd1) hit = 1'b1;
               end
               verdict_buf[verdict_wr % VERDICT_DEPTH] = hit;
               verdict_wr++;
               restart_match();
            end else begin
               match_hit = hit;
               if (p < MAX_LEN) match_pos = p + 9'd1;
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Sender: offer one item, hold it until taken, then idle in bursts
   // ---------------------------------------------------------------------
   task automatic send_item(op_type op, logic [5:0] idx, logic [7:0] pos, logic [7:0] ch,
                            logic last);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entry_index <= idx;
      req_position <= pos;
      req_char_byte <= ch;
      req_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_to_blocklist(op, idx, pos, ch, last);
      if (op != OP_NONE) items_sent++;
      if (!steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 15);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // Send name_buf[from..upto-1]; loads write position k, queries carry
   // random don't-care index and position fields.
   task automatic send_name_bytes(op_type op, int idx, int from, int upto, bit close);
      for (int k = from; k < upto; k++) begin
         if (op == OP_LOAD)
            send_item(op, 6'(idx), 8'(k), name_buf[k], close && k == upto - 1);
         else
            send_item(op, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                      name_buf[k], close && k == upto - 1);
      end
   endtask

   // Fill name_buf from a name written the usual way, reversing it
   function automatic void set_name(string s);
      name_len = s.len();
      for (int k = 0; k < name_len; k++) name_buf[k] = s[name_len - 1 - k];
   endfunction

   // Short random name over a tiny alphabet so that suffixes collide often
   function automatic void random_name();
      int labels;
      int n;
      labels = $urandom_range(1, 3);
      name_len = 0;
      for (int l = 0; l < labels; l++) begin
         if (l > 0) begin
            name_buf[name_len] = DOT_CHAR;
            name_len++;
         end
         n = $urandom_range(1, 4);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0)
               name_buf[name_len] = 8'($urandom_range(0, 255));
            else
               name_buf[name_len] = 8'h61 + 8'($urandom_range(0, 3));
            name_len++;
         end
      end
   endfunction

   // A load with last set reads back every lower position later: allow it
   // only where all of them were written.
   function automatic bit prefix_written(int idx, int pos);
      for (int k = 0; k < pos; k++)
         if (!row_written[idx][k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int pick_valid_entry();
      int hits [ENTRIES];
      int n_hits;
      n_hits = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (row_valid[i] && row_len[i] <= 40) begin
            hits[n_hits] = i;
            n_hits++;
         end
      if (n_hits == 0) return -1;
      return hits[$urandom_range(0, n_hits - 1)];
   endfunction

   // Build a query from an existing entry: equal, child, extended label,
   // truncated or with one bit flipped.
   function automatic void derive_query(int e);
      int n;
      int k;
      name_len = int'(row_len[e]);
      for (k = 0; k < name_len; k++) name_buf[k] = row_byte[e][k];
      case ($urandom_range(0, 4))
         1: begin
            name_buf[name_len] = DOT_CHAR;
            name_len++;
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
               name_buf[name_len] = 8'h61 + 8'($urandom_range(0, 3));
               name_len++;
            end
         end
         2: begin
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++) begin
               name_buf[name_len] = 8'h61 + 8'($urandom_range(0, 25));
               name_len++;
            end
         end
         3: if (name_len > 1) name_len = $urandom_range(1, name_len - 1);
         4: begin
            k = $urandom_range(0, name_len - 1);
            name_buf[k] = name_buf[k] ^ 8'(1 << $urandom_range(0, 7));
         end
         default: ;
      endcase
   endfunction

   task automatic noise_load();
      int idx;
      int pos;
      bit last;
      idx = $urandom_range(0, 63);
      pos = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
      last = 1'($urandom_range(0, 1));
      if (last && !prefix_written(idx, (pos >= MAX_LEN) ? MAX_LEN - 1 : pos)) last = 1'b0;
      send_item(OP_LOAD, 6'(idx), 8'(pos), 8'($urandom_range(0, 255)), last);
   endtask

   task automatic load_random_entries(int count);
      for (int n = 0; n < count; n++) begin
         random_name();
         send_name_bytes(OP_LOAD, $urandom_range(0, 63), 0, name_len, 1'b1);
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: its own stall pattern, plus a long hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_ack != hold_req) begin
         hold_ack = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         case (cycle_count[8:7])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (cycle_count[1:0] == 2'b00);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result check: compare each taken verdict with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_verdict
      bit want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_wr == verdict_rd) begin
            $error("forbidden: no verdict expected, got %0b", rsp_forbidden);
            fail_count++;
         end else begin
            want = verdict_buf[verdict_rd % VERDICT_DEPTH];
            verdict_rd++;
            if (rsp_forbidden !== want) begin
               $error("forbidden: expected %0b, got %0b", want, rsp_forbidden);
               fail_count++;
            end
            verdicts_checked++;
            if (want) verdicts_blocked++;
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d verdicts pending", cycle_count,
                  verdict_wr - verdict_rd);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Fresh table blocks nothing; an unused opcode gives no verdict.
   task automatic test_empty_table();
      set_name("a");
      send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
      send_item(OP_NONE, 6'h3F, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_NONE, 6'h00, 8'h00, 8'h00, 1'b0);
   endtask

   // Load the entries that the suffix probes run against.
   task automatic test_suffix_rules();
      set_name("ab.c");
      send_name_bytes(OP_LOAD, 0, 0, name_len, 1'b1);
      set_name("z");
      send_name_bytes(OP_LOAD, 63, 0, name_len, 1'b1);
   endtask

   // Equal names and children on a label boundary block; bare suffixes do not.
   task automatic test_suffix_queries();
      string probes [7];
      probes = '{"ab.c", "x.ab.c", "xab.c", "b.c", "z", "q.z", "zz"};
      foreach (probes[i]) begin
         set_name(probes[i]);
         send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
      end
   endtask

   // Invalidate an entry, revalidate it in the middle of a query, and use
   // extreme byte values.
   task automatic test_entry_updates();
      set_name("k.m");
      send_name_bytes(OP_LOAD, 1, 0, name_len, 1'b1);
      send_item(OP_LOAD, 6'd1, 8'hFF, 8'hFF, 1'b0);
      send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
      // start the child query while the entry is invalid, reload, finish
      set_name("a.k.m");
      send_name_bytes(OP_QUERY, 0, 0, 2, 1'b0);
      send_item(OP_LOAD, 6'd1, 8'd0, 8'h6D, 1'b0);
      send_item(OP_LOAD, 6'd1, 8'd1, DOT_CHAR, 1'b0);
      send_item(OP_LOAD, 6'd1, 8'd2, 8'h6B, 1'b1);
      send_name_bytes(OP_QUERY, 0, 2, name_len, 1'b1);
      name_buf[0] = 8'hFF;
      name_buf[1] = 8'h00;
      name_buf[2] = 8'h80;
      name_len = 3;
      send_name_bytes(OP_LOAD, 2, 0, name_len, 1'b1);
      send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
      name_buf[2] = 8'h7F;
      send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
   endtask

   // Clear abandons a query; stored bytes survive and can be revalidated.
   task automatic test_clear();
      set_name("ab.c");
      send_name_bytes(OP_QUERY, 0, 0, 2, 1'b0);
      send_item(OP_CLEAR, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'b1);
      send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
      send_item(OP_LOAD, 6'd0, 8'd3, 8'h61, 1'b1);
      send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
   endtask

   // Full-length entry and queries that run past the position limit.
   task automatic test_long_names();
      send_item(OP_CLEAR, 6'd0, 8'd0, 8'd0, 1'b0);
      for (int k = 0; k < MAX_LEN; k++)
         name_buf[k] = (k % 7 == 6) ? DOT_CHAR : 8'h61 + 8'(k % 26);
      name_len = MAX_LEN;
      send_name_bytes(OP_LOAD, 40, 0, MAX_LEN, 1'b1);
      send_name_bytes(OP_QUERY, 0, 0, MAX_LEN, 1'b1);
      // child of the full-length entry: boundary dot lands at the limit
      name_buf[MAX_LEN] = DOT_CHAR;
      name_buf[MAX_LEN + 1] = 8'h77;
      name_buf[MAX_LEN + 2] = 8'h77;
      send_name_bytes(OP_QUERY, 0, 0, MAX_LEN + 3, 1'b1);
      // same length, but no boundary: saturated position, no implicit dot
      name_buf[MAX_LEN] = 8'h78;
      name_buf[MAX_LEN + 1] = DOT_CHAR;
      name_buf[MAX_LEN + 2] = 8'h79;
      send_name_bytes(OP_QUERY, 0, 0, MAX_LEN + 3, 1'b1);
      send_item(OP_CLEAR, 6'd0, 8'd0, 8'd0, 1'b0);
   endtask

   // Hold the receiver off while short queries keep coming back to back.
   task automatic test_backpressure();
      string probes [3];
      probes = '{"p", "s", "x.p"};
      set_name("p");
      send_name_bytes(OP_LOAD, 9, 0, name_len, 1'b1);
      hold_req++;
      steady = 1'b1;
      for (int n = 0; n < 12; n++) begin
         set_name(probes[$urandom_range(0, 2)]);
         send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
      end
      steady = 1'b0;
   endtask

   // Mostly queries built from live entries, mixed with loads, noise,
   // clears and unused opcodes, until the item budget is spent.
   task automatic test_random_traffic();
      int e;
      int split;
      int pick;
      send_item(OP_CLEAR, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      load_random_entries(8);
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         pick = $urandom_range(0, 99);
         e = pick_valid_entry();
         if (pick < 60 && e >= 0) begin
            derive_query(e);
            send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
         end else if (pick < 75) begin
            random_name();
            send_name_bytes(OP_QUERY, 0, 0, name_len, 1'b1);
         end else if (pick < 87) begin
            load_random_entries(1);
         end else if (pick < 93) begin
            noise_load();
         end else if (pick < 96 && e >= 0) begin
            // load lands between bytes of a query
            derive_query(e);
            split = $urandom_range(0, name_len - 1);
            send_name_bytes(OP_QUERY, 0, 0, split, 1'b0);
            noise_load();
            send_name_bytes(OP_QUERY, 0, split, name_len, 1'b1);
         end else if (pick < 98) begin
            random_name();
            send_name_bytes(OP_QUERY, 0, 0, $urandom_range(0, name_len), 1'b0);
            send_item(OP_CLEAR, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            load_random_entries(4);
         end else begin
            send_item(OP_NONE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      restart_match();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_suffix_rules();
      test_suffix_queries();
      test_entry_updates();
      test_clear();
      test_long_names();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      // drain outstanding verdicts, then let the pipeline settle
      while (verdict_wr != verdict_rd) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d items (loads, queries, clears) in %0d cycles", items_sent,
               cycle_count);
      $display("Checked %0d verdicts, %0d blocked, %0d mismatches", verdicts_checked,
               verdicts_blocked, fail_count);
      if (fail_count == 0 && verdict_wr == verdict_rd) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
src/dsbl_pkg.sv
src/dsbl_ram.sv
src/dsbl_lane.sv
src/domain_suffix_blocklist_match.sv
dv/tb.sv
